@@ hw/rtl/ort_pkg.sv @@
package ort_pkg;

    // trig values: signed, TRIG_FRAC fraction bits, range -1.0 .. +1.0
    localparam int TRIG_FRAC = 16;
    localparam int TRIG_W    = TRIG_FRAC + 2;
    localparam int TRIG_LAT  = 6;

    // q30 taylor coefficients of sin(pi/2 * x), constant term first
    localparam logic [30:0] POLY_Q30 [0:4] = '{
        31'd1686629713, 31'd693598668, 31'd85569304, 31'd5026997, 31'd172272
    };

    // ceil(2^36 / 125): exact floor(u / 125) for u below 2^29
    localparam logic [29:0] RECIP_125 = 30'd549755814;

    // divider: dividend and divisor magnitudes
    localparam int DIV_NW = 53;
    localparam int DIV_DW = 27;

    // start-to-strobe latency in clock cycles
    localparam int LAT = TRIG_LAT + 7 + DIV_NW + 2;

endpackage

@@ hw/rtl/ort_sin.sv @@
module ort_sin
    import ort_pkg::*;
(
    input  logic                     i_clk,
    input  logic [15:0]              i_angle,
    output logic signed [TRIG_W-1:0] o_val
);

    localparam int RND_SH = 30 - TRIG_FRAC;
    localparam logic [31:0] ONE = 32'd1 << TRIG_FRAC;

    logic [14:0]          n_t;
    logic [29:0]          w_tsq;
    logic [14:0]          r_t   [0:4];
    logic [30:0]          r_x2  [0:3];
    logic                 r_neg [0:4];
    logic [30:0]          r_r   [0:4];
    logic [45:0]          w_ry;
    logic [31:0]          w_y;
    logic [31:0]          w_m;
    logic [TRIG_FRAC:0]   w_mag;
    logic signed [TRIG_W-1:0] r_val;

    // fold the angle into the first quadrant
    always_comb begin
        if (i_angle[14]) begin
            n_t = 15'(15'd16384 - {1'b0, i_angle[13:0]});
        end else begin
            n_t = {1'b0, i_angle[13:0]};
        end
        w_tsq = n_t * n_t;
    end

    always_ff @(posedge i_clk) begin
        r_t[0]   <= n_t;
        r_x2[0]  <= {w_tsq[28:0], 2'b00};
        r_neg[0] <= i_angle[15];
        r_r[0]   <= POLY_Q30[4];
    end

    // horner steps, one multiply per stage
    for (genvar k = 1; k < 5; k++) begin : g_step
        logic [61:0] w_prod;
        assign w_prod = r_r[k-1] * r_x2[k-1];
        always_ff @(posedge i_clk) begin
            r_r[k]   <= 31'(POLY_Q30[4-k] - w_prod[61:30]);
            r_t[k]   <= r_t[k-1];
            r_neg[k] <= r_neg[k-1];
        end
        if (k < 4) begin : g_x2
            always_ff @(posedge i_clk) begin
                r_x2[k] <= r_x2[k-1];
            end
        end
    end

    always_comb begin
        w_ry = r_r[4] * r_t[4];
        w_y  = w_ry[45:14];
        w_m  = (w_y + (32'd1 << (RND_SH - 1))) >> RND_SH;
        w_mag = (w_m > ONE) ? ONE[TRIG_FRAC:0] : w_m[TRIG_FRAC:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_neg[4]) begin
            r_val <= -$signed({1'b0, w_mag});
        end else begin
            r_val <= $signed({1'b0, w_mag});
        end
    end

    assign o_val = r_val;

endmodule

@@ hw/rtl/ort_div.sv @@
module ort_div
    import ort_pkg::*;
(
    input  logic              i_clk,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_NW-1:0] o_quo
);

    // restoring divider, one quotient bit per stage
    logic [DIV_DW-1:0] r_rem [0:DIV_NW-1];
    logic [DIV_NW-1:0] r_nq  [0:DIV_NW-1];
    logic [DIV_DW-1:0] r_den [0:DIV_NW-1];

    for (genvar j = 0; j < DIV_NW; j++) begin : g_bit
        logic [DIV_DW-1:0] w_rem;
        logic [DIV_NW-1:0] w_nq;
        logic [DIV_DW-1:0] w_den;
        logic [DIV_DW:0]   w_trial;
        logic              w_ge;
        if (j == 0) begin : g_first
            assign w_rem = '0;
            assign w_nq  = i_num;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_nq  = r_nq[j-1];
            assign w_den = r_den[j-1];
        end
        assign w_trial = {w_rem, w_nq[DIV_NW-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});
        always_ff @(posedge i_clk) begin
            r_rem[j] <= w_ge ? DIV_DW'(w_trial - {1'b0, w_den}) : w_trial[DIV_DW-1:0];
            r_nq[j]  <= {w_nq[DIV_NW-2:0], w_ge};
            r_den[j] <= w_den;
        end
    end

    assign o_quo = r_nq[DIV_NW-1];

endmodule

@@ hw/rtl/oriented_rect_overlap_test.sv @@
// Oriented rectangle overlap test. A request (start high while busy is low)
// carries two oriented rectangles; when it leaves the pipeline o_valid is
// high for one cycle with o_collide set when they overlap. The pipeline
// takes one request every clock cycle with no gaps, so busy is always low,
// and results come out in request order. Latency is set by the sine/cosine
// units (6 stages), the rotate-and-bound datapath (7 stages), the
// bit-per-stage divider (53 stages) and two closing stages. The receiver
// cannot stall: it must take o_collide in the cycle o_valid is high.
module oriented_rect_overlap_test
    import ort_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_first_x,
    input  logic signed [23:0] i_first_y,
    input  logic [15:0]        i_first_heading,
    input  logic [22:0]        i_first_width,
    input  logic [22:0]        i_first_height,
    input  logic signed [23:0] i_second_x,
    input  logic signed [23:0] i_second_y,
    input  logic [15:0]        i_second_heading,
    input  logic [22:0]        i_second_half_w,
    input  logic [22:0]        i_second_half_h,
    output logic               o_valid,
    output logic               o_collide
);

    localparam logic signed [54:0] SAT = 55'sd1099511627776;

    // pre-trig stages: offsets and one-third scaling of the first rectangle
    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [31:0]        pw;
        logic [31:0]        ph;
        logic [22:0]        hw;
        logic [22:0]        hh;
    } t_sa;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [58:0]        qw;
        logic [58:0]        qh;
        logic [22:0]        hw;
        logic [22:0]        hh;
    } t_sb;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [21:0]        w3;
        logic [21:0]        h3;
        logic [22:0]        hw;
        logic [22:0]        hh;
    } t_geo;

    // rotation products
    typedef struct packed {
        logic signed [42:0] dxc2;
        logic signed [42:0] dys2;
        logic signed [42:0] dyc2;
        logic signed [42:0] dxs2;
        logic signed [42:0] wc;
        logic signed [42:0] hs;
        logic signed [42:0] hc;
        logic signed [42:0] ws;
        logic [22:0]        hw;
        logic [22:0]        hh;
        logic               neg_prod;
        logic               zero_prod;
        logic               s_neg;
    } t_p1;

    typedef struct packed {
        logic signed [27:0] cx;
        logic signed [27:0] cy;
        logic signed [27:0] ax;
        logic signed [27:0] ay;
        logic signed [27:0] bx;
        logic signed [27:0] by;
        logic [22:0]        hw;
        logic [22:0]        hh;
        logic               neg_prod;
        logic               zero_prod;
        logic               s_neg;
    } t_p2;

    typedef struct packed {
        logic signed [29:0] blx;
        logic signed [29:0] ybot;
        logic signed [29:0] trx;
        logic signed [29:0] ytop;
        logic signed [27:0] ax;
        logic signed [27:0] ay;
        logic signed [27:0] bx;
        logic signed [27:0] by;
        logic               zero_prod;
    } t_p3;

    // per-side lanes: side 0 uses corner a, side 1 the mirrored corner -a
    typedef struct packed {
        logic signed [27:0] say;
        logic signed [27:0] dp;
        logic signed [27:0] dm;
        logic signed [27:0] np;
        logic signed [27:0] nm;
        logic signed [29:0] lo;
        logic signed [29:0] hi;
    } t_s4;

    typedef struct packed {
        t_s4 [1:0]          side;
        logic               miss;
        logic               zero_prod;
        logic signed [29:0] ybot;
        logic signed [29:0] ytop;
    } t_p4;

    typedef struct packed {
        logic               use_div;
        logic signed [27:0] say;
        logic signed [27:0] den;
        logic signed [27:0] num;
        logic signed [29:0] lv;
    } t_s5;

    typedef struct packed {
        t_s5 [1:0]          side;
        logic               miss;
        logic signed [29:0] ybot;
        logic signed [29:0] ytop;
    } t_p5;

    typedef struct packed {
        logic               use_div;
        logic signed [27:0] say;
        logic signed [27:0] den;
        logic signed [57:0] prod;
    } t_s6;

    typedef struct packed {
        t_s6 [1:0]          side;
        logic               miss;
        logic signed [29:0] ybot;
        logic signed [29:0] ytop;
    } t_p6;

    typedef struct packed {
        logic               use_div;
        logic               dz;
        logic               pneg;
        logic               pzero;
        logic               qneg;
        logic signed [27:0] say;
    } t_s7;

    typedef struct packed {
        t_s7 [1:0]          side;
        logic               miss;
        logic signed [29:0] ybot;
        logic signed [29:0] ytop;
    } t_tail;

    function automatic logic signed [27:0] f_rnd(input logic signed [43:0] v);
        logic signed [43:0] t;
        t = v + 44'sd32768;
        return t[43:16];
    endfunction

    logic                      w_acc;
    logic [15:0]               w_diff;
    logic signed [TRIG_W-1:0]  w_c2, w_s2, w_c, w_s;

    logic                      r_vt [0:TRIG_LAT-1];
    logic                      r_vp [0:6];
    logic                      r_vd [0:DIV_NW-1];
    logic                      r_ve;
    logic                      r_vo;

    t_sa   r_sa, n_sa;
    t_sb   r_sb, n_sb;
    t_geo  r_geo [0:3];
    t_geo  n_geo;
    t_p1   r_p1, n_p1;
    t_p2   r_p2, n_p2;
    t_p3   r_p3, n_p3;
    t_p4   r_p4, n_p4;
    t_p5   r_p5, n_p5;
    t_p6   r_p6, n_p6;
    t_tail r_p7, n_p7;
    logic [DIV_NW-1:0] r_nmag [0:1];
    logic [DIV_NW-1:0] n_nmag [0:1];
    logic [DIV_DW-1:0] r_dmag [0:1];
    logic [DIV_DW-1:0] n_dmag [0:1];
    logic [DIV_NW-1:0] w_quo  [0:1];
    t_tail r_dl [0:DIV_NW-1];
    logic signed [54:0] r_e [0:1];
    logic signed [54:0] n_e [0:1];
    logic               r_emiss;
    logic signed [29:0] r_ebot, r_etop;
    logic               r_hit, n_hit;

    // every cycle takes a request
    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    // heading difference wraps mod 2^16; cos(a) = sin(a + quarter turn)
    assign w_diff = i_first_heading - i_second_heading;

    ort_sin u_cos2 (.i_clk(i_clk), .i_angle(16'(i_second_heading + 16'd16384)), .o_val(w_c2));
    ort_sin u_sin2 (.i_clk(i_clk), .i_angle(i_second_heading), .o_val(w_s2));
    ort_sin u_cosd (.i_clk(i_clk), .i_angle(16'(w_diff + 16'd16384)), .o_val(w_c));
    ort_sin u_sind (.i_clk(i_clk), .i_angle(w_diff), .o_val(w_s));

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TRIG_LAT; k++) r_vt[k] <= 1'b0;
            for (int k = 0; k < 7; k++)        r_vp[k] <= 1'b0;
            for (int k = 0; k < DIV_NW; k++)   r_vd[k] <= 1'b0;
            r_ve <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_vt[0] <= w_acc;
            for (int k = 1; k < TRIG_LAT; k++) r_vt[k] <= r_vt[k-1];
            r_vp[0] <= r_vt[TRIG_LAT-1];
            for (int k = 1; k < 7; k++)        r_vp[k] <= r_vp[k-1];
            r_vd[0] <= r_vp[6];
            for (int k = 1; k < DIV_NW; k++)   r_vd[k] <= r_vd[k-1];
            r_ve <= r_vd[DIV_NW-1];
            r_vo <= r_ve;
        end
    end

    // stage a: center offset, width and height * 333 + 500
    always_comb begin
        n_sa.dx = 25'(i_second_x) - 25'(i_first_x);
        n_sa.dy = 25'(i_second_y) - 25'(i_first_y);
        n_sa.pw = 32'({9'd0, i_first_width} * 32'd333) + 32'd500;
        n_sa.ph = 32'({9'd0, i_first_height} * 32'd333) + 32'd500;
        n_sa.hw = i_second_half_w;
        n_sa.hh = i_second_half_h;
    end

    // stage b: divide by 1000 as (v / 8) * reciprocal of 125
    always_comb begin
        n_sb.dx = r_sa.dx;
        n_sb.dy = r_sa.dy;
        n_sb.qw = r_sa.pw[31:3] * RECIP_125;
        n_sb.qh = r_sa.ph[31:3] * RECIP_125;
        n_sb.hw = r_sa.hw;
        n_sb.hh = r_sa.hh;
    end

    always_comb begin
        n_geo.dx = r_sb.dx;
        n_geo.dy = r_sb.dy;
        n_geo.w3 = r_sb.qw[57:36];
        n_geo.h3 = r_sb.qh[57:36];
        n_geo.hw = r_sb.hw;
        n_geo.hh = r_sb.hh;
    end

    always_ff @(posedge i_clk) begin
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_geo[0] <= n_geo;
        for (int k = 1; k < 4; k++) r_geo[k] <= r_geo[k-1];
    end

    // p1: rotation products
    always_comb begin
        n_p1.dxc2 = 43'(r_geo[3].dx) * 43'(w_c2);
        n_p1.dys2 = 43'(r_geo[3].dy) * 43'(w_s2);
        n_p1.dyc2 = 43'(r_geo[3].dy) * 43'(w_c2);
        n_p1.dxs2 = 43'(r_geo[3].dx) * 43'(w_s2);
        n_p1.wc   = 43'($signed({1'b0, r_geo[3].w3})) * 43'(w_c);
        n_p1.hs   = 43'($signed({1'b0, r_geo[3].h3})) * 43'(w_s);
        n_p1.hc   = 43'($signed({1'b0, r_geo[3].h3})) * 43'(w_c);
        n_p1.ws   = 43'($signed({1'b0, r_geo[3].w3})) * 43'(w_s);
        n_p1.hw   = r_geo[3].hw;
        n_p1.hh   = r_geo[3].hh;
        n_p1.neg_prod  = (w_s < 0 && w_c > 0) || (w_s > 0 && w_c < 0);
        n_p1.zero_prod = (w_s == 0) || (w_c == 0);
        n_p1.s_neg     = (w_s < 0);
    end

    // p2: sums, rounded back to coordinate units
    always_comb begin
        n_p2.cx = f_rnd(44'(r_p1.dxc2) + 44'(r_p1.dys2));
        n_p2.cy = f_rnd(44'(r_p1.dyc2) - 44'(r_p1.dxs2));
        n_p2.ax = f_rnd(44'(r_p1.wc) - 44'(r_p1.hs));
        n_p2.ay = f_rnd(44'(r_p1.hc) + 44'(r_p1.ws));
        n_p2.bx = f_rnd(-44'(r_p1.hs) - 44'(r_p1.wc));
        n_p2.by = f_rnd(44'(r_p1.hc) - 44'(r_p1.ws));
        n_p2.hw = r_p1.hw;
        n_p2.hh = r_p1.hh;
        n_p2.neg_prod  = r_p1.neg_prod;
        n_p2.zero_prod = r_p1.zero_prod;
        n_p2.s_neg     = r_p1.s_neg;
    end

    // p3: second rectangle box, corner swap and mirror
    always_comb begin
        logic signed [27:0] bsx, bsy;
        n_p3.blx  = 30'(r_p2.cx) - 30'($signed({1'b0, r_p2.hw}));
        n_p3.trx  = 30'(r_p2.cx) + 30'($signed({1'b0, r_p2.hw}));
        n_p3.ybot = 30'(r_p2.cy) - 30'($signed({1'b0, r_p2.hh}));
        n_p3.ytop = 30'(r_p2.cy) + 30'($signed({1'b0, r_p2.hh}));
        n_p3.ax   = r_p2.neg_prod ? r_p2.bx : r_p2.ax;
        n_p3.ay   = r_p2.neg_prod ? r_p2.by : r_p2.ay;
        bsx       = r_p2.neg_prod ? r_p2.ax : r_p2.bx;
        bsy       = r_p2.neg_prod ? r_p2.ay : r_p2.by;
        n_p3.bx   = r_p2.s_neg ? -bsx : bsx;
        n_p3.by   = r_p2.s_neg ? -bsy : bsy;
        n_p3.zero_prod = r_p2.zero_prod;
    end

    // p4: horizontal reach test and per-side candidates
    always_comb begin
        logic signed [27:0] sax;
        n_p4.miss = (30'(r_p3.bx) > r_p3.trx) || (30'(r_p3.bx) > -r_p3.blx);
        n_p4.zero_prod = r_p3.zero_prod;
        n_p4.ybot = r_p3.ybot;
        n_p4.ytop = r_p3.ytop;
        for (int i = 0; i < 2; i++) begin
            sax = (i == 0) ? r_p3.ax : -r_p3.ax;
            n_p4.side[i].say = (i == 0) ? r_p3.ay : -r_p3.ay;
            n_p4.side[i].lo  = r_p3.blx - 30'(sax);
            n_p4.side[i].hi  = r_p3.trx - 30'(sax);
            n_p4.side[i].dp  = sax + r_p3.bx;
            n_p4.side[i].dm  = sax - r_p3.bx;
            n_p4.side[i].np  = n_p4.side[i].say + r_p3.by;
            n_p4.side[i].nm  = n_p4.side[i].say - r_p3.by;
        end
    end

    // p5: pick the corner that lies outside the range
    always_comb begin
        logic both_pos, both_neg;
        n_p5.miss = r_p4.miss;
        n_p5.ybot = r_p4.ybot;
        n_p5.ytop = r_p4.ytop;
        for (int i = 0; i < 2; i++) begin
            both_pos = (r_p4.side[i].hi > 0) && (r_p4.side[i].lo > 0);
            both_neg = (r_p4.side[i].hi < 0) && (r_p4.side[i].lo < 0);
            n_p5.side[i].use_div = (both_pos || both_neg) && !r_p4.zero_prod;
            n_p5.side[i].say     = r_p4.side[i].say;
            if (r_p4.side[i].lo < 0) begin
                n_p5.side[i].den = r_p4.side[i].dm;
                n_p5.side[i].num = r_p4.side[i].nm;
                n_p5.side[i].lv  = r_p4.side[i].hi;
            end else begin
                n_p5.side[i].den = r_p4.side[i].dp;
                n_p5.side[i].num = r_p4.side[i].np;
                n_p5.side[i].lv  = r_p4.side[i].lo;
            end
        end
    end

    // p6: dividend product
    always_comb begin
        n_p6.miss = r_p5.miss;
        n_p6.ybot = r_p5.ybot;
        n_p6.ytop = r_p5.ytop;
        for (int i = 0; i < 2; i++) begin
            n_p6.side[i].use_div = r_p5.side[i].use_div;
            n_p6.side[i].say     = r_p5.side[i].say;
            n_p6.side[i].den     = r_p5.side[i].den;
            n_p6.side[i].prod    = 58'(r_p5.side[i].num) * 58'(r_p5.side[i].lv);
        end
    end

    // p7: magnitudes and signs for the divider
    always_comb begin
        logic signed [57:0] pabs;
        logic signed [27:0] dabs;
        n_p7.miss = r_p6.miss;
        n_p7.ybot = r_p6.ybot;
        n_p7.ytop = r_p6.ytop;
        for (int i = 0; i < 2; i++) begin
            n_p7.side[i].use_div = r_p6.side[i].use_div;
            n_p7.side[i].say     = r_p6.side[i].say;
            n_p7.side[i].pneg    = (r_p6.side[i].prod < 0);
            n_p7.side[i].pzero   = (r_p6.side[i].prod == 0);
            n_p7.side[i].dz      = (r_p6.side[i].den == 0);
            n_p7.side[i].qneg    = (r_p6.side[i].prod < 0) ^ (r_p6.side[i].den < 0);
            pabs = (r_p6.side[i].prod < 0) ? -r_p6.side[i].prod : r_p6.side[i].prod;
            dabs = (r_p6.side[i].den < 0) ? -r_p6.side[i].den : r_p6.side[i].den;
            n_nmag[i] = pabs[DIV_NW-1:0];
            n_dmag[i] = dabs[DIV_DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= n_p1;
        r_p2 <= n_p2;
        r_p3 <= n_p3;
        r_p4 <= n_p4;
        r_p5 <= n_p5;
        r_p6 <= n_p6;
        r_p7 <= n_p7;
        for (int i = 0; i < 2; i++) begin
            r_nmag[i] <= n_nmag[i];
            r_dmag[i] <= n_dmag[i];
        end
        r_dl[0] <= r_p7;
        for (int k = 1; k < DIV_NW; k++) r_dl[k] <= r_dl[k-1];
    end

    ort_div u_div0 (.i_clk(i_clk), .i_num(r_nmag[0]), .i_den(r_dmag[0]), .o_quo(w_quo[0]));
    ort_div u_div1 (.i_clk(i_clk), .i_num(r_nmag[1]), .i_den(r_dmag[1]), .o_quo(w_quo[1]));

    // vertical extreme: bypass, saturated bound, or signed quotient
    always_comb begin
        logic signed [54:0] qs, say;
        for (int i = 0; i < 2; i++) begin
            say = 55'(r_dl[DIV_NW-1].side[i].say);
            qs  = $signed({2'b00, w_quo[i]});
            if (r_dl[DIV_NW-1].side[i].qneg) qs = -qs;
            if (!r_dl[DIV_NW-1].side[i].use_div) begin
                n_e[i] = say;
            end else if (r_dl[DIV_NW-1].side[i].dz) begin
                if (r_dl[DIV_NW-1].side[i].pzero) begin
                    n_e[i] = say;
                end else if (r_dl[DIV_NW-1].side[i].pneg) begin
                    n_e[i] = say - SAT;
                end else begin
                    n_e[i] = say + SAT;
                end
            end else begin
                n_e[i] = qs + say;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) r_e[i] <= n_e[i];
        r_emiss <= r_dl[DIV_NW-1].miss;
        r_ebot  <= r_dl[DIV_NW-1].ybot;
        r_etop  <= r_dl[DIV_NW-1].ytop;
    end

    // overlap unless the horizontal test missed or both extremes fall below or both rise above the box
    always_comb begin
        logic below, above;
        below = (r_e[0] < 55'(r_ebot)) && (r_e[1] < 55'(r_ebot));
        above = (r_e[0] > 55'(r_etop)) && (r_e[1] > 55'(r_etop));
        n_hit = !r_emiss && !(below || above);
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_valid   = r_vo;
    assign o_collide = r_hit;

endmodule

@@ hw/rtl/ort_checker.sv @@
module ort_checker
    import ort_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_collide
);

    // pipeline never pushes back
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // every result traces back to a request a fixed latency earlier
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without matching request");

    // reset flushes the pipeline
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

    // a strobed result always carries a known flag
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_collide))
        else $error("collide flag unknown at strobe");

endmodule

bind oriented_rect_overlap_test ort_checker u_ort_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_collide(o_collide)
);
